// ===== hdl/bmf_pkg.sv =====
// bmf_pkg: shared types, constants and helpers for the bracket match finder
// used by bmf_ctrl, bmf_datapath and bracket_match_finder; no dependencies
package bmf_pkg;

  localparam int MAX_CHARS_DEFAULT = 4096;
  localparam int CHAR_W  = 16;
  localparam int CURSOR_W = 13;
  localparam int INDEX_W = 12;

  localparam logic [CHAR_W-1:0] CH_LPAREN = 16'h0028;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 16'h0029;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 16'h005D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_RD_AT,
    ST_RD_BEF,
    ST_PICK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_POS_M1,
    RD_IDX
  } rd_sel_t;

  typedef struct packed {
    logic    load_en;
    logic    start;
    rd_sel_t rd_sel;
    logic    cap_at;
    logic    pick;
    logic    step;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    logic last_taken;
    logic range_ok;
    logic pick_none;
    logic scan_done;
    logic out_free;
  } sts_t;

  function automatic logic opens(input logic [CHAR_W-1:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic closes(input logic [CHAR_W-1:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  function automatic logic [CHAR_W-1:0] partner_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] p;
    case (c)
      CH_LPAREN: p = CH_RPAREN;
      CH_LBRACK: p = CH_RBRACK;
      CH_LBRACE: p = CH_RBRACE;
      CH_RPAREN: p = CH_LPAREN;
      CH_RBRACK: p = CH_LBRACK;
      CH_RBRACE: p = CH_LBRACE;
      default:   p = '1;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/bmf_ctrl.sv =====
// bmf_ctrl: sequencer for loading, bracket pick, depth scan and result hand-off
// depends on bmf_pkg
module bmf_ctrl
  import bmf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (sts.last_taken) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.range_ok ? ST_RD_AT : ST_RESULT;
      end
      ST_RD_AT:  state_next = ST_RD_BEF;
      ST_RD_BEF: state_next = ST_PICK;
      ST_PICK: begin
        state_next = sts.pick_none ? ST_RESULT : ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        state_next = sts.scan_done ? ST_RESULT : ST_SCAN_RD;
      end
      ST_RESULT: begin
        if (sts.out_free) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // publish is gated by the output register's free status in the datapath
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_IDX;
    case (state)
      ST_LOAD:     cmd.load_en = 1'b1;
      ST_CHECK:    cmd.start = 1'b1;
      ST_RD_AT:    cmd.rd_sel = RD_POS;
      ST_RD_BEF: begin
        cmd.rd_sel = RD_POS_M1;
        cmd.cap_at = 1'b1;
      end
      ST_PICK:     cmd.pick = 1'b1;
      ST_SCAN_RD:  cmd.rd_sel = RD_IDX;
      ST_SCAN_CHK: cmd.step = 1'b1;
      ST_RESULT:   cmd.publish = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== hdl/bmf_datapath.sv =====
// bmf_datapath: text memory, length and overflow tracking, scan registers, output beat
// depends on bmf_pkg; driven by bmf_ctrl through cmd_t / sts_t
module bmf_datapath
  import bmf_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                in_valid,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                has_char,
  input  logic                is_last,
  input  logic [CURSOR_W-1:0] cursor_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output logic [INDEX_W-1:0]  open_index,
  output logic [INDEX_W-1:0]  close_index,
  output logic                overflowed
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam int LW = $clog2(MAX_CHARS + 1);
  localparam int CW = (LW > CURSOR_W) ? LW : CURSOR_W;
  localparam logic [LW-1:0] CAP = LW'(MAX_CHARS);

  logic [CHAR_W-1:0] mem [MAX_CHARS];
  logic [CHAR_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;

  logic [LW-1:0]       len;
  logic                ovf;
  logic [CURSOR_W-1:0] pos;
  logic [CHAR_W-1:0]   c_at;
  logic [AW-1:0]       at;
  logic [AW-1:0]       idx;
  logic [CHAR_W-1:0]   self_ch;
  logic [CHAR_W-1:0]   other_ch;
  logic                fwd;
  logic [LW-1:0]       depth;
  logic                hit;
  logic [AW-1:0]       lo;
  logic [AW-1:0]       hi;

  logic          accept;
  logic          wr_en;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic          at_ok;
  logic          bef_ok;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] pos_m1_a;
  logic          pick_valid;
  logic [AW-1:0] pick_at;
  logic          pick_fwd;
  logic [CHAR_W-1:0] pick_ch;
  logic          is_match;
  logic          at_end;
  logic          out_free;
  logic          publish;

  assign accept = in_valid && cmd.load_en;
  assign wr_en  = accept && has_char && (len < CAP);

  assign out_free = !out_valid || !out_stall;
  assign publish  = cmd.publish && out_free;

  assign pos_ext  = CW'(pos);
  assign len_ext  = CW'(len);
  assign at_ok    = pos_ext < len_ext;
  assign bef_ok   = pos != '0;
  assign pos_a    = AW'(pos);
  assign pos_m1_a = AW'(pos - CURSOR_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:    rd_addr = pos_a;
      RD_POS_M1: rd_addr = pos_m1_a;
      RD_IDX:    rd_addr = idx;
      default:   rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(len)] <= char_code;
    end
    rd_data <= mem[rd_addr];
  end

  // choice of starting bracket, in order of preference
  always_comb begin
    pick_valid = 1'b1;
    pick_at    = pos_a;
    pick_fwd   = 1'b1;
    pick_ch    = c_at;
    if (at_ok && opens(c_at)) begin
      pick_at = pos_a;
    end else if (bef_ok && opens(rd_data)) begin
      pick_at = pos_m1_a;
      pick_ch = rd_data;
    end else if (at_ok && closes(c_at)) begin
      pick_fwd = 1'b0;
    end else if (bef_ok && closes(rd_data)) begin
      pick_at  = pos_m1_a;
      pick_ch  = rd_data;
      pick_fwd = 1'b0;
    end else begin
      pick_valid = 1'b0;
    end
  end

  assign is_match = (rd_data == other_ch) && (depth == LW'(1));
  assign at_end   = fwd ? (LW'(idx) == len - LW'(1)) : (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (wr_en) begin
        len <= len + LW'(1);
      end
      if (accept && has_char && (len == CAP)) begin
        ovf <= 1'b1;
      end
      if (cmd.start) begin
        hit <= 1'b0;
      end
      if (cmd.step && (rd_data != self_ch) && is_match) begin
        hit <= 1'b1;
      end
      if (publish) begin
        len <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      pos <= cursor_position;
    end
    if (cmd.cap_at) begin
      c_at <= rd_data;
    end
    if (cmd.pick) begin
      at       <= pick_at;
      idx      <= pick_at;
      fwd      <= pick_fwd;
      self_ch  <= pick_ch;
      other_ch <= partner_of(pick_ch);
      depth    <= '0;
    end
    if (cmd.step) begin
      if (rd_data == self_ch) begin
        depth <= depth + LW'(1);
      end else if (rd_data == other_ch) begin
        depth <= depth - LW'(1);
      end
      if (rd_data != self_ch && is_match) begin
        lo <= fwd ? at : idx;
        hi <= fwd ? idx : at;
      end
      if (!at_end) begin
        idx <= fwd ? idx + AW'(1) : idx - AW'(1);
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      found       <= hit;
      open_index  <= hit ? INDEX_W'(lo) : '0;
      close_index <= hit ? INDEX_W'(hi) : '0;
      overflowed  <= ovf;
    end
  end

  always_comb begin
    sts.last_taken = accept && is_last;
    sts.range_ok   = (len != '0) && (pos_ext <= len_ext);
    sts.pick_none  = !pick_valid;
    sts.scan_done  = ((rd_data != self_ch) && is_match) || at_end;
    sts.out_free   = out_free;
  end

endmodule

// ===== hdl/bracket_match_finder.sv =====
// Bracket match finder: text is loaded one character per beat into an on-chip buffer of
// MAX_CHARS entries; characters past capacity are dropped and reported as overflowed.
// Loading runs at one beat per cycle. The beat with is_last ends the text; input is then
// stalled while the cursor is checked, a bracket picked and the text scanned (each step is
// one read of the text memory), or only the check on empty text or a cursor out of range.
// The result beat waits in an output register, so loading of the next text may begin
// while it is still stalled downstream; the following result then waits until it has left.
// found=0 reports empty text, cursor out of range, no bracket next to the cursor or no
// matching partner. Indices are the low 12 bits.
module bracket_match_finder
  import bmf_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                has_char,
  input  logic                is_last,
  input  logic [CURSOR_W-1:0] cursor_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output logic [INDEX_W-1:0]  open_index,
  output logic [INDEX_W-1:0]  close_index,
  output logic                overflowed
);

  cmd_t cmd;
  sts_t sts;

  assign in_stall = !cmd.load_en;

  bmf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  bmf_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_valid        (in_valid),
    .char_code       (char_code),
    .has_char        (has_char),
    .is_last         (is_last),
    .cursor_position (cursor_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .found           (found),
    .open_index      (open_index),
    .close_index     (close_index),
    .overflowed      (overflowed)
  );

  // search follows the last beat, so input is held off on the next cycle
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_last) |=> in_stall)
    else $error("input taken straight after last beat");

  a_miss_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (open_index == '0 && close_index == '0))
    else $error("non-zero index on miss");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found && (MAX_CHARS <= 4096)) |-> (open_index < close_index))
    else $error("opener not before closer");

endmodule
